### design/dbpwm_pkg.sv
// Shared widths, codes and word types for the double-buffered four channel PWM.
// Used by double_buffered_four_channel_pwm; no dependencies of its own.
`default_nettype none

package dbpwm_pkg;

  localparam int CMD_W       = 2;
  localparam int DUTY_W      = 8;
  localparam int PERIOD_W    = 16;
  localparam int DIV_W       = 8;
  localparam int EDGE_W      = 16;
  localparam int MODE_W      = 2;
  localparam int DUE_W       = 8;
  localparam int TIME_W      = 32;
  localparam int DRIVE_W     = 4;
  localparam int DUTY_FIELDS = 4;
  localparam int PROD_W      = DUTY_W + PERIOD_W;
  localparam int FS_W        = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int FULL_SCALE_DEF = 255;
  localparam int CHANNELS_DEF   = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [DIV_W-1:0]    DIV_RESET    = 8'd1;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD   = 16'd4;
  localparam logic [EDGE_W-1:0]   MIN_EDGE     = 16'd2;
  localparam logic [DUE_W-1:0]    DUE_MAX      = 8'd255;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PWM  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DUTY_W-1:0] duty_left_b;
    logic [DUTY_W-1:0] duty_left_a;
    logic [DUTY_W-1:0] duty_right_b;
    logic [DUTY_W-1:0] duty_right_a;
  } in_word_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] motor_drive;
    logic               period_start;
    logic [DUE_W-1:0]   control_ticks;
    logic [TIME_W-1:0]  time_ticks;
  } out_word_t;

endpackage

`default_nettype wire

### design/double_buffered_four_channel_pwm.sv
// Double-buffered multi-channel PWM generator with control-tick divider.
// Depends on dbpwm_pkg for widths, codes and the in/out word types.
//
//   channel | ports                          | direction | handshake
//   --------+--------------------------------+-----------+------------------
//   input   | in_valid, in_stall, in_data    | in        | valid/stall
//   result  | out_valid, out_stall, out_data | out       | valid/stall
//   config  | cfg_we, cfg_index, cfg_data    | in        | write enable only
//
// One word a cycle sustained while out_stall is low; an accepted word passes the input then the result register.
// The input register holds duty times period; the second stage scales it by a
// constant reciprocal, updates the PWM state and loads the result register.
// Reset (rst_n low, synchronous) restores the register defaults and clears all
// counters, both frames and both valid flags.
// A stalled result holds the result register; the input register then fills
// and in_stall rises in the same cycle.
`default_nettype none

module double_buffered_four_channel_pwm #(
  parameter int FULL_SCALE = dbpwm_pkg::FULL_SCALE_DEF,
  parameter int CHANNELS   = dbpwm_pkg::CHANNELS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  dbpwm_pkg::in_word_t            in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output dbpwm_pkg::out_word_t                 out_data,
  input  wire                                  cfg_we,
  input  wire  [dbpwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [dbpwm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dbpwm_pkg::*;

  // exact floor division by FULL_SCALE for any product below 2^PROD_W
  localparam int SHIFT     = PROD_W + $clog2(FULL_SCALE);
  localparam int RECIP_W   = PROD_W + 1;
  localparam int SCALED_W  = SHIFT + EDGE_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << SHIFT) / FULL_SCALE + 64'd1);
  localparam logic [FS_W-1:0] FULL_SCALE_V = FS_W'(FULL_SCALE);

  // configuration
  logic [PERIOD_W-1:0] period_r;
  logic [DIV_W-1:0]    divider_r;
  logic [PERIOD_W-1:0] eff_period;
  logic [PERIOD_W-1:0] last_tick;

  // input register
  logic                s1_valid_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [DUTY_W-1:0]   s1_duty_r [DUTY_FIELDS];
  logic [PROD_W-1:0]   s1_prod_r [DUTY_FIELDS];
  logic [DUTY_W-1:0]   duty_in   [DUTY_FIELDS];
  logic                in_accept;
  logic                s1_adv;

  // PWM state
  logic [PERIOD_W-1:0] tip_r, tip_nxt;
  logic [EDGE_W-1:0]   act_edge_r [CHANNELS];
  logic [EDGE_W-1:0]   act_edge_nxt [CHANNELS];
  logic [MODE_W-1:0]   act_mode_r [CHANNELS];
  logic [MODE_W-1:0]   act_mode_nxt [CHANNELS];
  logic [EDGE_W-1:0]   sh_edge_r [CHANNELS];
  logic [EDGE_W-1:0]   sh_edge_nxt [CHANNELS];
  logic [MODE_W-1:0]   sh_mode_r [CHANNELS];
  logic [MODE_W-1:0]   sh_mode_nxt [CHANNELS];
  logic [EDGE_W-1:0]   map_edge [CHANNELS];
  logic [MODE_W-1:0]   map_mode [CHANNELS];
  logic                sh_pending_r, sh_pending_nxt;
  logic [DIV_W-1:0]    cpc_r, cpc_nxt;
  logic [DUE_W-1:0]    due_r, due_nxt, due_out;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic                boundary;
  logic [DIV_W-1:0]    cpc_inc;
  logic [DRIVE_W-1:0]  drive_nxt;

  // result register
  logic                out_valid_r;
  out_word_t           out_data_r;

  assign eff_period = (period_r < MIN_PERIOD) ? MIN_PERIOD : period_r;
  assign last_tick  = eff_period - PERIOD_W'(1);

  assign duty_in[0] = in_data.duty_left_b;
  assign duty_in[1] = in_data.duty_left_a;
  assign duty_in[2] = in_data.duty_right_b;
  assign duty_in[3] = in_data.duty_right_a;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RESET;
      divider_r <= DIV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:  period_r  <= cfg_data[PERIOD_W-1:0];
        CFG_DIVIDER: divider_r <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // hold duty and duty*period; the divide by full scale happens next stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r <= in_data.cmd;
      for (int i = 0; i < DUTY_FIELDS; i++) begin
        s1_duty_r[i] <= duty_in[i];
        s1_prod_r[i] <= PROD_W'(duty_in[i]) * PROD_W'(eff_period);
      end
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_map
    if (ch < DUTY_FIELDS) begin : g_field
      logic [SCALED_W-1:0] scaled;
      logic [EDGE_W-1:0]   quo;
      logic [EDGE_W-1:0]   clamped;

      assign scaled  = SCALED_W'(s1_prod_r[ch]) * SCALED_W'(RECIP);
      assign quo     = scaled[SHIFT +: EDGE_W];
      assign clamped = (quo < MIN_EDGE) ? MIN_EDGE :
                       (quo > last_tick) ? last_tick : quo;

      always_comb begin
        if (s1_duty_r[ch] == '0) begin
          map_mode[ch] = MODE_OFF;
          map_edge[ch] = '0;
        end else if ({{(FS_W-DUTY_W){1'b0}}, s1_duty_r[ch]} >= FULL_SCALE_V) begin
          map_mode[ch] = MODE_FULL;
          map_edge[ch] = '0;
        end else begin
          map_mode[ch] = MODE_PWM;
          map_edge[ch] = clamped;
        end
      end
    end else begin : g_spare
      assign map_mode[ch] = MODE_OFF;
      assign map_edge[ch] = '0;
    end
  end

  always_comb begin
    boundary       = 1'b0;
    tip_nxt        = tip_r;
    time_nxt       = time_r;
    cpc_nxt        = cpc_r;
    due_nxt        = due_r;
    sh_pending_nxt = sh_pending_r;
    cpc_inc        = cpc_r + DIV_W'(1);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      act_edge_nxt[ch] = act_edge_r[ch];
      act_mode_nxt[ch] = act_mode_r[ch];
      sh_edge_nxt[ch]  = sh_edge_r[ch];
      sh_mode_nxt[ch]  = sh_mode_r[ch];
    end

    case (s1_cmd_r)
      CMD_TICK: begin
        time_nxt = time_r + TIME_W'(1);
        if (tip_r >= last_tick) begin
          boundary = 1'b1;
          tip_nxt  = '0;
          if (sh_pending_r) begin
            sh_pending_nxt = 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
              act_edge_nxt[ch] = sh_edge_r[ch];
              act_mode_nxt[ch] = sh_mode_r[ch];
            end
          end
          // divider register of zero behaves as one
          if (cpc_inc >= divider_r) begin
            cpc_nxt = '0;
            if (due_r < DUE_MAX) begin
              due_nxt = due_r + DUE_W'(1);
            end
          end else begin
            cpc_nxt = cpc_inc;
          end
        end else begin
          tip_nxt = tip_r + PERIOD_W'(1);
        end
      end
      CMD_SUBMIT: begin
        sh_pending_nxt = 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          sh_edge_nxt[ch] = map_edge[ch];
          sh_mode_nxt[ch] = map_mode[ch];
        end
      end
      CMD_STOP: begin
        sh_pending_nxt = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          act_edge_nxt[ch] = '0;
          act_mode_nxt[ch] = MODE_OFF;
          sh_edge_nxt[ch]  = '0;
          sh_mode_nxt[ch]  = MODE_OFF;
        end
      end
      default: ;
    endcase

    // report the count before a take clears it
    due_out = due_nxt;
    if (s1_cmd_r == CMD_TAKE) begin
      due_nxt = '0;
    end
  end

  for (genvar b = 0; b < DRIVE_W; b++) begin : g_drive
    if (b < CHANNELS) begin : g_live
      assign drive_nxt[b] = (act_mode_nxt[b] == MODE_FULL) ||
                            ((act_mode_nxt[b] == MODE_PWM) && (tip_nxt < act_edge_nxt[b]));
    end else begin : g_dead
      assign drive_nxt[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_r        <= '0;
      sh_pending_r <= 1'b0;
      cpc_r        <= '0;
      due_r        <= '0;
      time_r       <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        act_edge_r[ch] <= '0;
        act_mode_r[ch] <= MODE_OFF;
        sh_edge_r[ch]  <= '0;
        sh_mode_r[ch]  <= MODE_OFF;
      end
    end else if (s1_adv) begin
      tip_r        <= tip_nxt;
      sh_pending_r <= sh_pending_nxt;
      cpc_r        <= cpc_nxt;
      due_r        <= due_nxt;
      time_r       <= time_nxt;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        act_edge_r[ch] <= act_edge_nxt[ch];
        act_mode_r[ch] <= act_mode_nxt[ch];
        sh_edge_r[ch]  <= sh_edge_nxt[ch];
        sh_mode_r[ch]  <= sh_mode_nxt[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.motor_drive   <= drive_nxt;
      out_data_r.period_start  <= boundary;
      out_data_r.control_ticks <= due_out;
      out_data_r.time_ticks    <= time_nxt;
    end
  end

`ifndef SYNTHESIS
  a_time_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r != CMD_TICK)) |=> (time_r == $past(time_r)))
    else $error("time count moved on a non-tick word");

  a_start_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r != CMD_TICK)) |=> !out_data_r.period_start)
    else $error("period start flagged on a non-tick word");

  a_stop_drives_low: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r == CMD_STOP)) |=> ((out_data_r.motor_drive == '0) && !sh_pending_r))
    else $error("outputs or shadow frame not cleared after stop");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
